@@ hw/rtl/rpn_pkg.sv @@
// shared types and constants of the rpn stack calculator
// word format, command codes, stream widths and the multiply/divide unit handshake
// no dependencies
`default_nettype none

package rpn_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CMD_W = 3;

  // quotient width, shifted product width and the wider of the two
  localparam int unsigned QUOT_W = WORD_BITS + FRAC_BITS;
  localparam int unsigned PROD_W = 2 * WORD_BITS - FRAC_BITS;
  localparam int unsigned MAG_W  = (QUOT_W > PROD_W) ? QUOT_W : PROD_W;
  localparam int unsigned CNT_W  = $clog2(QUOT_W + 1);

  localparam int unsigned S_TDATA_W = ((CMD_W + WORD_BITS + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((4 * WORD_BITS + 2 + 7) / 8) * 8;

  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
  localparam logic [WORD_BITS-1:0] WORD_MAX = ~WORD_MIN;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic                 done;
    logic                 ovf;
    logic [WORD_BITS-1:0] result;
  } md_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/rpn_muldiv.sv @@
// iterative fixed-point multiply and divide with one shared adder
// shift-and-add multiply, restoring divide, sign handling and saturation
// depends on rpn_pkg
`default_nettype none

module rpn_muldiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpn_pkg::md_req_t              req_i,
  input  logic [rpn_pkg::WORD_BITS-1:0] a_i,
  input  logic [rpn_pkg::WORD_BITS-1:0] b_i,
  output rpn_pkg::md_rsp_t              rsp_o
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RUN  = 3'b010,
    MD_PACK = 3'b100
  } md_state_e;

  md_state_e              state_q, state_d;
  logic                   div_q, div_d;
  logic                   neg_q, neg_d;
  logic [WORD_BITS-1:0]   dvs_q, dvs_d;
  logic [WORD_BITS-1:0]   rem_q, rem_d;
  logic [QUOT_W-1:0]      sh_q, sh_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic [WORD_BITS-1:0]   mag_a, mag_b;
  logic [WORD_BITS:0]     add_a, add_b;
  logic                   add_sub;
  logic [WORD_BITS+1:0]   add_sum;
  logic                   ge;

  logic [2*WORD_BITS-1:0] prod;
  logic [MAG_W-1:0]       mag;
  logic [WORD_BITS-1:0]   limit, sat_mag;
  logic                   ovf;

  assign mag_a = a_i[WORD_BITS-1] ? WORD_BITS'(-a_i) : a_i;
  assign mag_b = b_i[WORD_BITS-1] ? WORD_BITS'(-b_i) : b_i;

  // shared adder
  always_comb begin
    if (div_q) begin
      add_a   = {rem_q, sh_q[QUOT_W-1]};
      add_b   = {1'b0, dvs_q};
      add_sub = 1'b1;
    end else begin
      add_a   = {1'b0, rem_q};
      add_b   = sh_q[0] ? {1'b0, dvs_q} : '0;
      add_sub = 1'b0;
    end
  end

  assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                 + (WORD_BITS + 2)'(add_sub);
  assign ge      = add_sum[WORD_BITS+1];

  // saturation of the final magnitude
  assign prod    = {rem_q, sh_q[WORD_BITS-1:0]};
  assign mag     = div_q ? MAG_W'(sh_q) : MAG_W'(prod[2*WORD_BITS-1:FRAC_BITS]);
  assign limit   = neg_q ? WORD_MIN : WORD_MAX;
  assign ovf     = mag > MAG_W'(limit);
  assign sat_mag = ovf ? limit : mag[WORD_BITS-1:0];

  assign rsp_o.done   = (state_q == MD_PACK);
  assign rsp_o.ovf    = ovf;
  assign rsp_o.result = neg_q ? WORD_BITS'(-sat_mag) : sat_mag;

  always_comb begin
    state_d = state_q;
    div_d   = div_q;
    neg_d   = neg_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          div_d   = req_i.is_div;
          neg_d   = a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
          rem_d   = '0;
          state_d = MD_RUN;
          if (req_i.is_div) begin
            sh_d  = QUOT_W'(mag_a) << FRAC_BITS;
            dvs_d = mag_b;
            cnt_d = CNT_W'(QUOT_W);
          end else begin
            sh_d  = QUOT_W'(mag_b);
            dvs_d = mag_a;
            cnt_d = CNT_W'(WORD_BITS);
          end
        end
      end
      MD_RUN: begin
        if (div_q) begin
          rem_d = ge ? add_sum[WORD_BITS-1:0] : add_a[WORD_BITS-1:0];
          sh_d  = {sh_q[QUOT_W-2:0], ge};
        end else begin
          rem_d            = add_sum[WORD_BITS:1];
          sh_d             = sh_q >> 1;
          sh_d[WORD_BITS-1] = add_sum[0];
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = MD_PACK;
        end
      end
      MD_PACK: begin
        state_d = MD_IDLE;
      end
      default: begin
        state_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/rpn_stack_calculator.sv @@
// top level of the four-level rpn stack calculator (x, y, z, t) in signed q16.16
// stream in/out, stack registers, add/subtract, command sequencer
// depends on rpn_pkg and rpn_muldiv
`default_nettype none

// Each input item carries a command (push, add, subtract, multiply, divide) and a
// value used by push. Every item yields exactly one output item with the whole
// stack after the step and the divide_error and overflow flags. The block takes
// one item at a time: s_axis_tready is high only while the sequencer is idle, and
// a finished result may still wait in the output register while the next item
// is accepted. Push, add, subtract and unused codes go from the accept straight
// to the done state, which holds until the output register is free, then back to
// idle. Multiply and divide pass through the calc state while the shared adder of
// the shift-and-add multiplier and restoring divider retires one bit a cycle.
// Division by zero skips the calc state and leaves the stack unchanged.

module rpn_stack_calculator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rpn_pkg::S_TDATA_W-1:0] s_axis_tdata,  // cmd, value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rpn_pkg::M_TDATA_W-1:0] m_axis_tdata   // x_reg, y_reg, z_reg, t_reg,
                                                       // divide_error, overflow
);
  import rpn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic [WORD_BITS-1:0]   value_q, value_d;
  logic [WORD_BITS-1:0]   res_q, res_d;
  logic                   ovf_q, ovf_d;
  logic [WORD_BITS-1:0]   x_q, x_d, y_q, y_d, z_q, z_d, t_q, t_d;
  logic                   m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0]   m_data_q, m_data_d;

  logic                   accept, out_free;
  cmd_e                   in_cmd;
  logic signed [WORD_BITS:0] as_sum;
  logic                   as_ovf;
  logic [WORD_BITS-1:0]   as_res;
  logic                   derr, ovf_out;

  md_req_t                md_req;
  md_rsp_t                md_rsp;

  rpn_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (y_q),
    .b_i    (x_q),
    .rsp_o  (md_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tdata[CMD_W-1:0]);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // saturating add and subtract of y and x
  assign as_sum = (cmd_q == CMD_SUB)
                ? $signed({y_q[WORD_BITS-1], y_q}) - $signed({x_q[WORD_BITS-1], x_q})
                : $signed({y_q[WORD_BITS-1], y_q}) + $signed({x_q[WORD_BITS-1], x_q});
  assign as_ovf = as_sum[WORD_BITS] ^ as_sum[WORD_BITS-1];
  assign as_res = as_ovf ? (as_sum[WORD_BITS] ? WORD_MIN : WORD_MAX)
                         : as_sum[WORD_BITS-1:0];

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    value_d       = value_q;
    res_d         = res_q;
    ovf_d         = ovf_q;
    x_d           = x_q;
    y_d           = y_q;
    z_d           = z_q;
    t_d           = t_q;
    m_valid_d     = m_valid_q & ~m_axis_tready;
    m_data_d      = m_data_q;
    md_req.start  = 1'b0;
    md_req.is_div = 1'b0;
    derr          = 1'b0;
    ovf_out       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = in_cmd;
          value_d = s_axis_tdata[CMD_W +: WORD_BITS];
          if (in_cmd == CMD_MUL || (in_cmd == CMD_DIV && x_q != '0)) begin
            md_req.start  = 1'b1;
            md_req.is_div = (in_cmd == CMD_DIV);
            state_d       = ST_CALC;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CALC: begin
        if (md_rsp.done) begin
          res_d   = md_rsp.result;
          ovf_d   = md_rsp.ovf;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          unique case (cmd_q)
            CMD_PUSH: begin
              t_d = z_q;
              z_d = y_q;
              y_d = x_q;
              x_d = value_q;
            end
            CMD_ADD, CMD_SUB: begin
              x_d     = as_res;
              y_d     = z_q;
              z_d     = t_q;
              ovf_out = as_ovf;
            end
            CMD_MUL: begin
              x_d     = res_q;
              y_d     = z_q;
              z_d     = t_q;
              ovf_out = ovf_q;
            end
            CMD_DIV: begin
              if (x_q == '0) begin
                derr = 1'b1;
              end else begin
                x_d     = res_q;
                y_d     = z_q;
                z_d     = t_q;
                ovf_out = ovf_q;
              end
            end
            default: begin
            end
          endcase
          m_valid_d = 1'b1;
          m_data_d  = M_TDATA_W'({ovf_out, derr, t_d, z_d, y_d, x_d});
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      t_q       <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      t_q       <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    value_q  <= value_d;
    res_q    <= res_d;
    ovf_q    <= ovf_d;
    m_data_q <= m_data_d;
  end

endmodule

`default_nettype wire

@@ bench/tb_rpn_stack_calculator.sv @@
// self-checking bench for the rpn stack calculator: directed corner items, then random phases
// with sender idling and receiver stalls, every output item checked against a q16.16 stack model
// depends on rpn_pkg and rpn_stack_calculator
`default_nettype none

module tb_rpn_stack_calculator;
  timeunit 1ns;
  timeprecision 1ps;

  import rpn_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 460;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic  ovf;
    logic  derr;
    word_t t;
    word_t z;
    word_t y;
    word_t x;
  } stack_view_t;

  localparam int unsigned VIEW_W = $bits(stack_view_t);

  localparam word_t ONE_Q      = word_t'(32'h0001_0000);
  localparam word_t MINUS_ONE_Q = word_t'(32'hFFFF_0000);

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  word_t stk_x = '0;
  word_t stk_y = '0;
  word_t stk_z = '0;
  word_t stk_t = '0;

  stack_view_t expected_stacks[$];
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned cycle_count = 0;

  rpn_stack_calculator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] magnitude(word_t w);
    logic signed [63:0] wide;
    wide = w;
    return (wide < 0) ? -wide : wide;
  endfunction

  function automatic word_t saturate(logic neg, logic [63:0] mag, output logic ovf);
    logic [63:0] lim;
    logic [63:0] signed_val;
    lim = neg ? {32'b0, WORD_MIN} : {32'b0, WORD_MAX};
    ovf = 1'b0;
    if (mag > lim) begin
      mag = lim;
      ovf = 1'b1;
    end
    signed_val = neg ? (64'd0 - mag) : mag;
    return signed_val[WORD_BITS-1:0];
  endfunction

  function automatic stack_view_t next_stack(logic [CMD_W-1:0] cmd, word_t value);
    stack_view_t view;
    logic signed [WORD_BITS:0] sum;
    logic [63:0] mag_r;
    logic neg;
    logic ovf;
    logic derr;
    logic drop;
    word_t res;
    ovf  = 1'b0;
    derr = 1'b0;
    drop = 1'b0;
    res  = '0;
    neg  = stk_y[WORD_BITS-1] ^ stk_x[WORD_BITS-1];
    case (cmd)
      CMD_PUSH: begin
        stk_t = stk_z;
        stk_z = stk_y;
        stk_y = stk_x;
        stk_x = value;
      end
      CMD_ADD, CMD_SUB: begin
        if (cmd == CMD_ADD) sum = {stk_y[WORD_BITS-1], stk_y} + {stk_x[WORD_BITS-1], stk_x};
        else sum = {stk_y[WORD_BITS-1], stk_y} - {stk_x[WORD_BITS-1], stk_x};
        if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
          res = sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
          ovf = 1'b1;
        end else begin
          res = sum[WORD_BITS-1:0];
        end
        drop = 1'b1;
      end
      CMD_MUL: begin
        mag_r = (magnitude(stk_y) * magnitude(stk_x)) >> FRAC_BITS;
        res   = saturate(neg, mag_r, ovf);
        drop  = 1'b1;
      end
      CMD_DIV: begin
        if (stk_x == '0) begin
          derr = 1'b1;
        end else begin
          mag_r = (magnitude(stk_y) << FRAC_BITS) / magnitude(stk_x);
          res   = saturate(neg, mag_r, ovf);
          drop  = 1'b1;
        end
      end
      default: ;
    endcase
    if (drop) begin
      stk_x = res;
      stk_y = stk_z;
      stk_z = stk_t;
    end
    view.x    = stk_x;
    view.y    = stk_y;
    view.z    = stk_z;
    view.t    = stk_t;
    view.derr = derr;
    view.ovf  = ovf;
    return view;
  endfunction

  function automatic word_t random_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return word_t'($urandom);
      4, 5, 6:    return word_t'($urandom_range(20'hFFFFF)) - word_t'(20'h80000);
      7, 8:       return word_t'($urandom) >>> 10;
      default: begin
        case ($urandom_range(6))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return '0;
          3:       return '1;
          4:       return word_t'(1);
          5:       return ONE_Q;
          default: return MINUS_ONE_Q;
        endcase
      end
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_item(input logic [CMD_W-1:0] cmd, input word_t value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= S_TDATA_W'({value, cmd});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_stacks.push_back(next_stack(cmd, value));
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_stacks.size() != 0) @(negedge clk_i);
  endtask

  task automatic note_mismatch(input string field, input logic [WORD_BITS-1:0] want,
                               input logic [WORD_BITS-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin : check_results
    stack_view_t got;
    stack_view_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = stack_view_t'(m_axis_tdata[VIEW_W-1:0]);
      if (expected_stacks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("output item with nothing pending: x %h y %h", got.x, got.y);
      end else begin
        want = expected_stacks.pop_front();
        if (got.x != want.x) note_mismatch("x_reg", want.x, got.x);
        if (got.y != want.y) note_mismatch("y_reg", want.y, got.y);
        if (got.z != want.z) note_mismatch("z_reg", want.z, got.z);
        if (got.t != want.t) note_mismatch("t_reg", want.t, got.t);
        if (got.derr != want.derr) note_mismatch("divide_error", 32'(want.derr), 32'(got.derr));
        if (got.ovf != want.ovf) note_mismatch("overflow", 32'(want.ovf), 32'(got.ovf));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // lift through all four levels with the word extremes
  task automatic test_push_lift();
    send_item(CMD_PUSH, WORD_MAX);
    send_item(CMD_PUSH, WORD_MIN);
    send_item(CMD_PUSH, '0);
    send_item(CMD_PUSH, '1);
  endtask

  // plain add/subtract, then saturation on both ends
  task automatic test_add_sub_saturation();
    send_item(CMD_ADD, '0);
    send_item(CMD_SUB, '1);
    send_item(CMD_SUB, WORD_MAX);
    send_item(CMD_ADD, WORD_MIN);
    send_item(CMD_PUSH, WORD_MIN);
    send_item(CMD_PUSH, word_t'(1));
    send_item(CMD_SUB, '0);
  endtask

  task automatic test_multiply();
    send_item(CMD_PUSH, word_t'(32'h0001_8000));
    send_item(CMD_PUSH, word_t'(32'hFFFE_0000));
    send_item(CMD_MUL, '1);
    send_item(CMD_PUSH, WORD_MAX);
    send_item(CMD_MUL, '0);
  endtask

  // division by zero, then a quotient that overflows positive (WORD_MIN by minus one)
  task automatic test_divide();
    send_item(CMD_PUSH, '0);
    send_item(CMD_DIV, WORD_MAX);
    send_item(CMD_PUSH, WORD_MIN);
    send_item(CMD_PUSH, MINUS_ONE_Q);
    send_item(CMD_DIV, '0);
  endtask

  task automatic test_unused_codes();
    for (int c = int'(CMD_DIV) + 1; c < (1 << CMD_W); c++)
      send_item(CMD_W'(c), word_t'($urandom));
  endtask

  // mostly operand pushes followed by one operation, with some raw noise
  task automatic test_random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                                   input int unsigned n_items);
    int unsigned sent;
    int unsigned pushes;
    logic [CMD_W-1:0] code;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        code = CMD_W'($urandom_range((1 << CMD_W) - 1));
        send_item(code, word_t'($urandom));
        if (code <= CMD_DIV) sent++;
      end else begin
        pushes = ($urandom_range(3) == 0) ? 2 : 1;
        repeat (pushes) begin
          send_item(CMD_PUSH, random_value());
          sent++;
        end
        case ($urandom_range(3))
          0:       code = CMD_ADD;
          1:       code = CMD_SUB;
          2:       code = CMD_MUL;
          default: code = CMD_DIV;
        endcase
        if (code == CMD_DIV && $urandom_range(7) == 0) begin
          send_item(CMD_PUSH, '0);
          sent++;
        end
        send_item(code, word_t'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_push_lift();
    test_add_sub_saturation();
    test_multiply();
    test_divide();
    test_unused_codes();
    wait_results_drained();
    test_random_phase(0, 0, PHASE_ITEMS);
    wait_results_drained();
    test_random_phase(59, 0, PHASE_ITEMS);
    wait_results_drained();
    test_random_phase(0, 59, PHASE_ITEMS);
    wait_results_drained();
    test_random_phase(21, 21, PHASE_ITEMS);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += expected_stacks.size();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ rpn_stack_calculator.f @@
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_muldiv.sv
hw/rtl/rpn_stack_calculator.sv
bench/tb_rpn_stack_calculator.sv
